[hdl/keg_pkg.sv]
`timescale 1ns / 1ps
package keg_pkg;

    // input word width, fixed by the interface
    localparam int IN_W = 24;

    // taylor terms of the exponential segment
    localparam int EXP_TERMS = 16;

    // signed accumulator width of the exponential sum (q0.32 plus sign and headroom)
    localparam int SUM_W = 35;

    // register stages inside each segment datapath, and the full latency
    localparam int SUB_DEPTH = 4 + 2 * EXP_TERMS;
    localparam int OUT_LAT   = SUB_DEPTH + 1;

    typedef enum logic [2:0] {
        SEG_ONE,
        SEG_LIN,
        SEG_EXP,
        SEG_ROOT,
        SEG_RECIP
    } seg_t;

endpackage

[hdl/keg_exp.sv]
`timescale 1ns / 1ps
module keg_exp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic [keg_pkg::SUB_DEPTH-1:0]       en,
    input  logic [keg_pkg::IN_W-2:0]            xp,
    output logic signed [keg_pkg::SUM_W-1:0]    sum
);
    import keg_pkg::*;

    localparam int SH = 32 - FRAC_BITS;
    localparam longint unsigned MA = ((64'd1 << 37) + 64'd99) / 64'd100;
    localparam longint unsigned MU = ((64'd1 << 36) + 64'd99) / 64'd100;
    localparam logic signed [SUM_W-1:0] S0 = SUM_W'(64'h1_0000_0000);

    // exponent argument t = 0.95 v in q0.32, built over four stages
    logic [29:0] a_reg;
    logic [29:0] a2_reg;
    logic [23:0] qa_reg;
    logic [23:0] qa3_reg;
    logic [28:0] u_reg;
    logic [31:0] t_reg;

    logic [60:0] qa_prod;
    logic [23:0] qa_next;
    logic [6:0]  r_next;
    logic [28:0] u_next;
    logic [58:0] uq_prod;
    logic [55:0] t_full;

    always_comb
    begin
        qa_prod = 61'(a_reg) * 61'(MA);
        qa_next = qa_prod[60:37];
        r_next  = 7'(a2_reg - 30'(qa_reg) * 30'd100);
        u_next  = (29'(r_next) << SH) + 29'd50;
        uq_prod = 59'(u_reg) * 59'(MU);
        t_full  = (56'(qa3_reg) << SH) + 56'(uq_prod[58:36]);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_reg <= 30'(xp) * 30'd95;
        end
        if (en[1])
        begin
            qa_reg <= qa_next;
            a2_reg <= a_reg;
        end
        if (en[2])
        begin
            u_reg   <= u_next;
            qa3_reg <= qa_reg;
        end
        if (en[3])
        begin
            t_reg <= t_full[31:0];
        end
    end

    // alternating taylor sum, two stages per term: multiply by t, then divide by k
    logic [31:0]             p_reg    [1:EXP_TERMS];
    logic [31:0]             ta_reg   [1:EXP_TERMS];
    logic [31:0]             tb_reg   [1:EXP_TERMS];
    logic signed [SUM_W-1:0] sa_reg   [1:EXP_TERMS];
    logic signed [SUM_W-1:0] sb_reg   [1:EXP_TERMS];
    logic [32:0]             term_reg [1:EXP_TERMS];

    for (genvar k = 1; k <= EXP_TERMS; k++)
    begin : g_term
        localparam int K   = k;
        localparam int LK  = $clog2(K);
        localparam longint unsigned MK = ((64'd1 << (32 + LK)) + 64'(K - 1)) / 64'(K);
        localparam bit ODD = (K % 2) == 1;

        logic [32:0]             term_in;
        logic [31:0]             t_in;
        logic signed [SUM_W-1:0] s_in;
        logic [64:0]             pr;
        logic [64:0]             qp;
        logic [32:0]             q;

        if (k == 1)
        begin : g_first
            assign term_in = 33'h1_0000_0000;
            assign t_in    = t_reg;
            assign s_in    = S0;
        end
        else
        begin : g_next
            assign term_in = term_reg[k-1];
            assign t_in    = tb_reg[k-1];
            assign s_in    = sb_reg[k-1];
        end

        always_comb
        begin
            pr = 65'(term_in) * 65'(t_in);
            qp = 65'(p_reg[k]) * 65'(MK);
            q  = 33'(qp >> (32 + LK));
        end

        always_ff @(posedge clk)
        begin
            if (en[2*k+2])
            begin
                p_reg[k]  <= pr[63:32];
                ta_reg[k] <= t_in;
                sa_reg[k] <= s_in;
            end
            if (en[2*k+3])
            begin
                term_reg[k] <= q;
                tb_reg[k]   <= ta_reg[k];
                if (ODD)
                begin
                    sb_reg[k] <= sa_reg[k] - $signed(SUM_W'(q));
                end
                else
                begin
                    sb_reg[k] <= sa_reg[k] + $signed(SUM_W'(q));
                end
            end
        end
    end

    assign sum = sb_reg[EXP_TERMS];

endmodule

[hdl/keg_digit.sv]
`timescale 1ns / 1ps
module keg_digit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic [keg_pkg::SUB_DEPTH-1:0] en,
    input  logic [keg_pkg::IN_W-2:0]      xp,
    output logic [FRAC_BITS:0]            root_gain,
    output logic [FRAC_BITS:0]            recip_gain
);
    import keg_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int GW = F + 1;

    // square root segment
    localparam int NW  = F + 6;
    localparam int R   = F + 6;
    localparam int RW  = 2 * R + 1;
    localparam int PAD = SUB_DEPTH - (R + 4);
    localparam longint unsigned N0 = 64'd38 << F;
    localparam longint unsigned MC = 64'd1184 << (2 * F);
    localparam longint unsigned C40 = (64'd40 << F) + 64'd50;
    localparam longint unsigned MR = ((64'd1 << (NW + 7)) + 64'd99) / 64'd100;

    logic [NW-1:0] n_reg;
    logic [RW-1:0] m_reg;
    logic [RW-1:0] rem_reg  [0:R-1];
    logic [R-1:0]  root_reg [0:R-1];
    logic [NW-1:0] num_reg;
    logic [GW-1:0] rg_reg;
    logic [GW-1:0] rp_reg   [1:PAD];

    logic [2*NW-1:0] sq;
    logic [NW-1:0]   num_next;
    logic [2*NW:0]   rprod;

    always_comb
    begin
        sq       = (2*NW)'(n_reg) * (2*NW)'(n_reg);
        // round the root up, then 0.4 - root in units of 1/100
        num_next = NW'(C40) - NW'(root_reg[R-1])
                 - ((rem_reg[R-1] != '0) ? NW'(1) : NW'(0));
        rprod    = (2*NW+1)'(num_reg) * (2*NW+1)'(MR);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            n_reg <= NW'(N0) - NW'(34'(xp) * 34'd10);
        end
        if (en[1])
        begin
            m_reg <= RW'(MC) - RW'(sq);
        end
        if (en[R+2])
        begin
            num_reg <= num_next;
        end
        if (en[R+3])
        begin
            rg_reg <= GW'(rprod >> (NW + 7));
        end
    end

    for (genvar j = 0; j < R; j++)
    begin : g_root
        localparam int I = R - 1 - j;

        logic [RW-1:0] rem_in;
        logic [R-1:0]  root_in;
        logic [RW-1:0] trial;

        if (j == 0)
        begin : g_first
            assign rem_in  = m_reg;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
        end

        assign trial = (RW'(root_in) << (I + 1)) | (RW'(1) << (2 * I));

        always_ff @(posedge clk)
        begin
            if (en[2+j])
            begin
                if (rem_in >= trial)
                begin
                    rem_reg[j]  <= rem_in - trial;
                    root_reg[j] <= root_in | (R'(1) << I);
                end
                else
                begin
                    rem_reg[j]  <= rem_in;
                    root_reg[j] <= root_in;
                end
            end
        end
    end

    for (genvar p = 1; p <= PAD; p++)
    begin : g_rpad
        if (p == 1)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en[R+3+p])
                begin
                    rp_reg[p] <= rg_reg;
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (en[R+3+p])
                begin
                    rp_reg[p] <= rp_reg[p-1];
                end
            end
        end
    end

    assign root_gain = rp_reg[PAD];

    // reciprocal segment: restoring division, one quotient bit per stage
    localparam int QB   = F - 2;
    localparam int DW   = 30;
    localparam int ND   = 2 * F + 6;
    localparam int CW   = ((ND > DW + QB) ? ND : DW + QB) + 1;
    localparam int PAD2 = SUB_DEPTH - (QB + 1);
    localparam longint unsigned C18 = 64'd18 << (2 * F);

    logic [CW-1:0] dnum_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] drem_reg [0:QB-1];
    logic [DW-1:0] dden_reg [0:QB-1];
    logic [QB-1:0] q_reg    [0:QB-1];
    logic [QB-1:0] qd_reg   [1:PAD2];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dnum_reg <= CW'(C18) + CW'(CW'(xp) * CW'(40));
            den_reg  <= DW'(xp) * DW'(80);
        end
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_div
        localparam int I = QB - 1 - j;

        logic [CW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QB-1:0] q_in;
        logic [CW-1:0] dsh;

        if (j == 0)
        begin : g_first
            assign rem_in = dnum_reg;
            assign den_in = den_reg;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign rem_in = drem_reg[j-1];
            assign den_in = dden_reg[j-1];
            assign q_in   = q_reg[j-1];
        end

        assign dsh = CW'(den_in) << I;

        always_ff @(posedge clk)
        begin
            if (en[1+j])
            begin
                dden_reg[j] <= den_in;
                if (rem_in >= dsh)
                begin
                    drem_reg[j] <= rem_in - dsh;
                    q_reg[j]    <= q_in | (QB'(1) << I);
                end
                else
                begin
                    drem_reg[j] <= rem_in;
                    q_reg[j]    <= q_in;
                end
            end
        end
    end

    for (genvar p = 1; p <= PAD2; p++)
    begin : g_dpad
        if (p == 1)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en[QB+p])
                begin
                    qd_reg[p] <= q_reg[QB-1];
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (en[QB+p])
                begin
                    qd_reg[p] <= qd_reg[p-1];
                end
            end
        end
    end

    assign recip_gain = GW'(qd_reg[PAD2]);

endmodule

[hdl/knife_edge_diffraction_gain_core.sv]
`timescale 1ns / 1ps
// knife-edge diffraction gain, piecewise approximation of the fresnel integral
// input channel: in_valid / in_ready carry diffraction_param, v in signed q8.16
// (FRAC_BITS fraction bits); output channel: out_valid / out_ready carry gain,
// unsigned with FRAC_BITS fraction bits, 1.0 = 2^FRAC_BITS, rounded and clamped
// to 0..1
// every transaction in gives exactly one transaction out, in order
// pipeline depth is set by the sixteen-term taylor series of the exponential
// segment (two stages per term: multiply, divide)
// throughput: one transaction per cycle while out_ready is high; the four computed
// segments run in parallel lanes of equal depth and the last stage picks by segment code
// stalls: each stage has a valid bit; a stage loads whenever out_ready is high or it
// or any stage after it is empty, so bubbles close up and the input keeps taking
// transactions while a result waits at the output register
// reset: clears the valid bits only, the pipeline comes up empty with in_ready
// high; there is no other state and no configuration
module knife_edge_diffraction_gain_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [keg_pkg::IN_W-1:0] diffraction_param,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [FRAC_BITS:0]            gain
);
    import keg_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int GW = F + 1;
    localparam int LW = F + 2;
    localparam int SH = 32 - F;
    localparam logic signed [31:0] ONE_S = 32'sd1 <<< F;
    localparam logic signed [31:0] BND_S = 32'sd24 <<< F;
    localparam longint unsigned ML = ((64'd1 << 37) + 64'd99) / 64'd100;

    // valid per stage; a stage advances on out_ready or if it or a later stage is empty
    logic [OUT_LAT:1] valid_reg;
    logic [OUT_LAT:1] valid_next;
    logic [OUT_LAT:1] valid_src;
    logic [OUT_LAT:1] rdy;

    for (genvar j = 1; j <= OUT_LAT; j++)
    begin : g_rdy
        assign rdy[j] = out_ready || !(&valid_reg[OUT_LAT:j]);
    end

    // what each stage would take: the stage before it, or the input for the first
    assign valid_src = {valid_reg[OUT_LAT-1:1], in_valid};

    always_comb
    begin
        valid_next = valid_reg;
        for (int j = 1; j <= OUT_LAT; j++)
        begin
            if (rdy[j])
            begin
                valid_next[j] = valid_src[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = rdy[1];
    assign out_valid = valid_reg[OUT_LAT];

    // segment decode and the linear lane
    logic signed [31:0] xs;
    logic [IN_W-2:0]    xp;
    logic [23:0]        nx;
    seg_t               seg_next;
    logic [29:0]        lin_v_next;
    logic [60:0]        lin_prod;
    logic [LW-1:0]      lin_next;

    seg_t          seg_reg [1:SUB_DEPTH];
    logic [29:0]   lin_v_reg;
    logic [LW-1:0] lin_reg [2:SUB_DEPTH];

    always_comb
    begin
        xs = 32'(diffraction_param);
        xp = diffraction_param[IN_W-2:0];
        nx = 24'(-xs);
        if (xs < -ONE_S)
        begin
            seg_next = SEG_ONE;
        end
        else if (xs <= 32'sd0)
        begin
            seg_next = SEG_LIN;
        end
        else if (xs <= ONE_S)
        begin
            seg_next = SEG_EXP;
        end
        else if (xs * 32'sd10 <= BND_S)
        begin
            seg_next = SEG_ROOT;
        end
        else
        begin
            seg_next = SEG_RECIP;
        end
        lin_v_next = 30'(nx) * 30'd62 + 30'd50;
        lin_prod   = 61'(lin_v_reg) * 61'(ML);
        lin_next   = (LW'(1) << (F - 1)) + LW'(lin_prod[60:37]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            seg_reg[1] <= seg_next;
            lin_v_reg  <= lin_v_next;
        end
        if (rdy[2])
        begin
            lin_reg[2] <= lin_next;
        end
        for (int j = 2; j <= SUB_DEPTH; j++)
        begin
            if (rdy[j])
            begin
                seg_reg[j] <= seg_reg[j-1];
            end
        end
        for (int j = 3; j <= SUB_DEPTH; j++)
        begin
            if (rdy[j])
            begin
                lin_reg[j] <= lin_reg[j-1];
            end
        end
    end

    // exponential lane and the two digit-recurrence lanes
    logic signed [SUM_W-1:0] exp_sum;
    logic [GW-1:0]           root_gain;
    logic [GW-1:0]           recip_gain;

    keg_exp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_exp (
        .clk (clk),
        .en  (rdy[SUB_DEPTH:1]),
        .xp  (xp),
        .sum (exp_sum)
    );

    keg_digit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_digit (
        .clk        (clk),
        .en         (rdy[SUB_DEPTH:1]),
        .xp         (xp),
        .root_gain  (root_gain),
        .recip_gain (recip_gain)
    );

    // output stage: round the exponential sum, pick the lane, saturate at 1.0
    logic [SUM_W-1:0] exp_pos;
    logic [SUM_W-1:0] exp_rnd;
    logic [LW-1:0]    pick;
    logic [GW-1:0]    gain_next;
    logic [GW-1:0]    gain_reg;

    always_comb
    begin
        exp_pos = (exp_sum < 0) ? '0 : SUM_W'(exp_sum);
        exp_rnd = (exp_pos + (SUM_W'(1) << SH)) >> (SH + 1);
        case (seg_reg[SUB_DEPTH])
            SEG_ONE:   pick = LW'(1) << F;
            SEG_LIN:   pick = lin_reg[SUB_DEPTH];
            SEG_EXP:   pick = LW'(exp_rnd);
            SEG_ROOT:  pick = LW'(root_gain);
            SEG_RECIP: pick = LW'(recip_gain);
            default:   pick = '0;
        endcase
        if (pick > (LW'(1) << F))
        begin
            gain_next = GW'(1) << F;
        end
        else
        begin
            gain_next = GW'(pick);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[OUT_LAT])
        begin
            gain_reg <= gain_next;
        end
    end

    assign gain = gain_reg;

    // an empty output stage means the whole pipeline can take a transaction
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[OUT_LAT] |-> in_ready)
        else $error("output stage empty but input not ready");

    // gain never leaves the 0..1 range
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gain <= (GW'(1) << F)))
        else $error("gain above 1.0");

    // an accepted transaction always lands in the first stage
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[1])
        else $error("accepted transaction lost at first stage");

endmodule

[tb/sv/knife_edge_diffraction_gain_core_test.sv]
`timescale 1ns / 1ps
module knife_edge_diffraction_gain_core_test;
    import keg_pkg::*;

    localparam int FB = 16;
    localparam int N_RANDOM = 930;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = OUT_LAT + 20;

    // idling phases of the random part
    typedef enum int {
        PH_NONE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } phase_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [IN_W-1:0] diffraction_param;
    logic out_valid;
    logic out_ready;
    logic [FB:0] gain;

    // golden gains waiting for their output transaction
    logic [FB:0] gain_queue[$];
    int mismatches;
    int idle_cycles;
    int send_idle_pct;
    int recv_stall_pct;
    bit long_hold;
    bit stim_done;

    knife_edge_diffraction_gain_core #(
        .FRAC_BITS(FB)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .diffraction_param(diffraction_param),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .gain(gain)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // integer square root, floor
    function automatic longint unsigned root_floor(longint unsigned m);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > m)
            b = b >> 2;
        while (b != 0)
        begin
            if (m >= res + b)
            begin
                m = m - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // piecewise knife-edge gain in fixed point, rounded and clamped to 0..1
    function automatic logic [FB:0] knife_gain(logic signed [IN_W-1:0] v);
        longint x;
        longint one;
        longint g;
        longint unsigned t;
        longint unsigned term;
        longint sum;
        longint unsigned m;
        longint unsigned s;
        longint n;
        x = v;
        one = 64'sd1 << FB;
        if (x < -one)
            g = one;
        else if (x <= 0)
            g = (one >>> 1) + longint'((62 * longint'(-x) + 50) / 100);
        else if (x <= one)
        begin
            // 0.95v in q0.32, then alternating taylor sum of exp(-t)
            t = (longint'(95) * x * (64'd1 << (32 - FB)) + 50) / 100;
            term = 64'd1 << 32;
            sum = longint'(term);
            for (int k = 1; k <= EXP_TERMS; k++)
            begin
                term = ((term * t) >> 32) / k;
                if (k % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            g = longint'((longint'(sum) + (64'd1 << (32 - FB))) >> (33 - FB));
        end
        else if (10 * x <= 24 * one)
        begin
            n = 38 * one - 10 * x;
            m = 64'd1184 * (64'd1 << (2 * FB)) - longint'(n * n);
            s = root_floor(m);
            if (s * s < m)
                s = s + 1;
            g = 40 * one + 50 - longint'(s);
            g = (g < 0) ? 0 : g / 100;
        end
        else
            g = (18 * (64'sd1 << (2 * FB)) + 40 * x) / (80 * x);
        if (g > one)
            g = one;
        if (g < 0)
            g = 0;
        return g[FB:0];
    endfunction

    task automatic report_mismatch(string what, logic [FB:0] got, logic [FB:0] want);
        $display("mismatch %s: gain got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // offer one transaction and hold it until accepted
    task automatic send_param(logic signed [IN_W-1:0] v, logic [FB:0] want);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        diffraction_param <= v;
        gain_queue.push_back(want);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // receiver: random stalls, plus a long hold when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (long_hold)
            out_ready <= 1'b0;
        else
            out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    // output checker, compares against the oldest golden gain
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (gain_queue.size() == 0)
                report_mismatch("unexpected transaction", gain, '0);
            else if (gain !== gain_queue[0])
                report_mismatch("value", gain, gain_queue.pop_front());
            else
                void'(gain_queue.pop_front());
        end
    end

    // watchdog, counts cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
            idle_cycles <= 0;
        else if (rst_n && !stim_done)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // directed rows: input and, where obvious, the expected gain
    typedef struct {
        logic signed [IN_W-1:0] v;
        bit typed;
        logic [FB:0] want;
    } row_t;

    row_t directed[] = '{
        '{24'sh800000, 1, 17'd65536},   // most negative
        '{-24'sd65537, 1, 17'd65536},   // just below -1
        '{-24'sd65536, 1, 17'd65536},   // -1, linear clamps at 1.0
        '{-24'sd52850, 0, 17'd0},       // linear near the clamp
        '{-24'sd32768, 0, 17'd0},
        '{-24'sd1, 0, 17'd0},
        '{24'sd0, 1, 17'd32768},        // zero, exactly one half
        '{24'sd1, 0, 17'd0},            // first exponential point
        '{24'sd32768, 0, 17'd0},
        '{24'sd65536, 0, 17'd0},        // v = 1, end of exponential
        '{24'sd65537, 0, 17'd0},        // first square-root point
        '{24'sd100000, 0, 17'd0},
        '{24'sd157286, 0, 17'd0},       // last square-root point, just below v = 2.4
        '{24'sd157287, 0, 17'd0},       // first reciprocal point
        '{24'sd1000000, 0, 17'd0},
        '{24'sh7fffff, 0, 17'd0},       // most positive
        '{24'sh555555, 0, 17'd0},
        '{24'shaaaaaa, 1, 17'd65536}
    };

    initial
    begin
        phase_t ph;
        logic signed [IN_W-1:0] v;
        int pick;
        rst_n = 1'b0;
        in_valid = 1'b0;
        diffraction_param = '0;
        mismatches = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold = 1'b0;
        stim_done = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_param(directed[i].v,
                directed[i].typed ? directed[i].want : knife_gain(directed[i].v));

        // fill the pipeline against a stalled receiver
        fork
        begin
            long_hold = 1'b1;
            repeat (3 * OUT_LAT) @(posedge clk);
            long_hold = 1'b0;
        end
        join_none

        for (int i = 0; i < N_RANDOM; i++)
        begin
            ph = phase_t'((i / 60) % 4);
            case (ph)
                PH_NONE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                PH_SEND_IDLE:  begin send_idle_pct = 49; recv_stall_pct = 0;  end
                PH_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default:       begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            // mostly the interesting range -3..3, some full-width noise
            pick = $urandom_range(9);
            if (pick < 7)
                v = IN_W'($signed($urandom_range(393216)) - 196608);
            else
                v = IN_W'($urandom);
            send_param(v, knife_gain(v));
        end
        in_valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        while (gain_queue.size() != 0)
            @(posedge clk);
        stim_done = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
